// ===== design/png_size_probe_macros.svh =====
// Assertion helpers used by png_size_probe.
`ifndef PNG_SIZE_PROBE_MACROS_SVH
`define PNG_SIZE_PROBE_MACROS_SVH

// Clocked check, off while reset is held.
`define PSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PSP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/pngsp_pkg.sv =====
package pngsp_pkg;

    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_HDR  = 3'd1,
        PH_DATA = 3'd2,
        PH_CRC  = 3'd3,
        PH_DONE = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOT_PNG = 3'd1,
        ST_SHORT   = 3'd2,
        ST_TRUNC   = 3'd3,
        ST_NO_SIZE = 3'd4
    } t_status;

    localparam logic [31:0] IHDR_TYPE = 32'h4948_4452;
    localparam logic [31:0] IHDR_LEN  = 32'd13;

    typedef struct packed {
        t_status     status;
        logic [31:0] width;
        logic [31:0] height;
    } t_result;

    // PNG signature, one byte per position
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            3'd7:    b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== design/png_size_probe.sv =====
// PNG size probe: feed a PNG file one byte per item on s_axis (tlast on the
// buffer's final byte); the block checks the signature, walks the chunks
// (length, type, data, CRC) and emits at most one result per buffer on m_axis:
// status in tuser, IHDR width and height in tdata (zero unless status is OK).
// Status codes: 0 ok, 1 not PNG, 2 short chunk header, 3 truncated chunk,
// 4 no or zero size. Bytes after a result are swallowed until tlast, and tlast
// always returns the parser to the start of a new buffer.
// Rate: one byte per clock, sustained while the output buffer has room. A result is
// written into the output buffer and reaches m_axis behind any earlier result
// that still waits there. Results queue in a two-entry output buffer;
// s_axis_tready falls only while both entries wait on m_axis_tready.
`include "png_size_probe_macros.svh"

module png_size_probe import pngsp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,   // is_last
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] image_width, [63:32] image_height
    output logic [2:0]  m_axis_tuser    // [2:0] status
);

    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out;
    logic    w_full;
    logic    w_res_ok;
    logic    w_dims_set;
    logic    w_dims_zero;

    // the output buffer has room whenever it is not full, so any byte may enter
    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    pngsp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    pngsp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_full  (w_full),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {w_out.height, w_out.width};
    assign m_axis_tuser = w_out.status;

    // result classification for the checks below
    assign w_res_ok    = w_res_valid && (w_res.status == ST_OK);
    assign w_dims_set  = (w_res.width != '0) && (w_res.height != '0);
    assign w_dims_zero = (w_res.width == '0) && (w_res.height == '0);

    // backpressure only comes from a full result queue
    `PSP_ASSERT(a_stall_means_pending, !s_axis_tready |-> m_axis_tvalid, "stall without pending result")
    // an OK result carries nonzero dimensions
    `PSP_ASSERT(a_ok_nonzero, w_res_ok |-> w_dims_set, "OK result with zero size")
    // an error result carries zero dimensions
    `PSP_ASSERT(a_err_zero, (w_res_valid && !w_res_ok) |-> w_dims_zero, "error with nonzero size")
    // results only come from accepted bytes
    `PSP_ASSERT_ALWAYS(a_res_on_accept, w_res_valid |-> w_accept, "result without accepted byte")

endmodule

// ===== design/pngsp_parser.sv =====
module pngsp_parser import pngsp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_count, n_count;
    logic [63:0] r_shift, n_shift;
    logic [31:0] r_remain, n_remain;
    logic        r_size, n_size;
    logic [31:0] r_width, n_width;
    logic [31:0] r_height, n_height;

    logic        emit;
    t_result     res;
    logic [31:0] rem_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SIG;
            r_count  <= '0;
            r_shift  <= '0;
            r_remain <= '0;
            r_size   <= 1'b0;
            r_width  <= '0;
            r_height <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_shift  <= n_shift;
            r_remain <= n_remain;
            r_size   <= n_size;
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_shift  = r_shift;
        n_remain = r_remain;
        n_size   = r_size;
        n_width  = r_width;
        n_height = r_height;
        emit     = 1'b0;
        res      = '{status: ST_OK, width: '0, height: '0};
        rem_dec  = (r_remain != '0) ? r_remain - 32'd1 : r_remain;

        case (r_phase)
            PH_SIG: begin
                if (i_byte != sig_byte(r_count)) begin
                    emit       = 1'b1;
                    res.status = ST_NOT_PNG;
                end else if (r_count == 3'd7) begin
                    n_phase = PH_HDR;
                    n_count = '0;
                    n_shift = '0;
                    if (i_last) begin
                        emit       = 1'b1;
                        res.status = ST_SHORT;
                    end
                end else begin
                    n_count = r_count + 3'd1;
                    if (i_last) begin
                        emit       = 1'b1;
                        res.status = ST_NOT_PNG;
                    end
                end
            end
            PH_HDR: begin
                n_shift = {r_shift[55:0], i_byte};
                n_count = r_count + 3'd1;
                if (i_last) begin
                    emit       = 1'b1;
                    res.status = ST_SHORT;
                end else if (r_count == 3'd7) begin
                    n_size   = (n_shift[63:32] == IHDR_LEN) && (n_shift[31:0] == IHDR_TYPE);
                    n_remain = n_shift[63:32];
                    n_width  = '0;
                    n_height = '0;
                    n_count  = '0;
                    n_phase  = (n_shift[63:32] == '0) ? PH_CRC : PH_DATA;
                end
            end
            PH_DATA: begin
                // width in data bytes 0..3, height in 4..7
                if (r_size) begin
                    if (r_remain inside {[32'd10:32'd13]}) begin
                        n_width = {r_width[23:0], i_byte};
                    end else if (r_remain inside {[32'd6:32'd9]}) begin
                        n_height = {r_height[23:0], i_byte};
                    end
                end
                n_remain = rem_dec;
                if (rem_dec == '0) begin
                    if (r_size) begin
                        emit = 1'b1;
                        if (n_width == '0 || n_height == '0) begin
                            res.status = ST_NO_SIZE;
                        end else begin
                            res.status = ST_OK;
                            res.width  = n_width;
                            res.height = n_height;
                        end
                    end else begin
                        n_phase = PH_CRC;
                        n_count = '0;
                        if (i_last) begin
                            emit       = 1'b1;
                            res.status = ST_TRUNC;
                        end
                    end
                end else if (i_last) begin
                    emit       = 1'b1;
                    res.status = ST_TRUNC;
                end
            end
            PH_CRC: begin
                n_count = r_count + 3'd1;
                if (r_count == 3'd3) begin
                    if (i_last) begin
                        emit       = 1'b1;
                        res.status = ST_NO_SIZE;
                    end else begin
                        n_phase = PH_HDR;
                        n_count = '0;
                        n_shift = '0;
                    end
                end else if (i_last) begin
                    emit       = 1'b1;
                    res.status = ST_TRUNC;
                end
            end
            default: begin
            end
        endcase

        if (emit) begin
            n_phase = PH_DONE;
        end
        // final byte: start over for the next buffer
        if (i_last) begin
            n_phase  = PH_SIG;
            n_count  = '0;
            n_shift  = '0;
            n_remain = '0;
            n_size   = 1'b0;
            n_width  = '0;
            n_height = '0;
        end
    end

    assign o_res_valid = i_accept && emit;
    assign o_res       = res;

endmodule

// ===== design/pngsp_out_fifo.sv =====
module pngsp_out_fifo import pngsp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_pop,
    output logic    o_valid,
    output logic    o_full,
    output t_result o_data
);

    t_result    r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;

    logic do_pop;

    assign do_pop = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rptr];

endmodule

// ===== test/tb_png_size_probe.sv =====
import pngsp_pkg::*;

localparam logic [63:0] PNG_SIGNATURE = 64'h8950_4E47_0D0A_1A0A;

// Tracks the expected probe result for each buffer. Bytes go in as the
// block accepts them, and results are compared against the oldest expectation.
class png_dims_scoreboard;
    t_result     expected_dims[$];
    int unsigned fail_count;
    int unsigned results_checked;
    int unsigned status_seen[5];

    // parser state, mirrors the block
    t_phase      phase;
    logic [31:0] count;
    logic [63:0] hdr_shift;
    logic [31:0] remaining;
    bit          size_chunk;
    logic [31:0] w_hold;
    logic [31:0] h_hold;

    function new();
        fail_count      = 0;
        results_checked = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        clear_state();
    endfunction

    function void clear_state();
        phase      = PH_SIG;
        count      = '0;
        hdr_shift  = '0;
        remaining  = '0;
        size_chunk = 1'b0;
        w_hold     = '0;
        h_hold     = '0;
    endfunction

    // Advance the parser by one accepted byte, queue a result if one falls out.
    function void take_byte(input logic [7:0] b, input logic last);
        t_result     r;
        bit          got;
        logic [31:0] len;
        logic [31:0] kind;
        logic [31:0] idx;
        got = 1'b0;
        r   = '0;
        case (phase)
            PH_SIG: begin
                if (b != PNG_SIGNATURE[8*(7 - count[2:0]) +: 8]) begin
                    got = 1'b1;
                    r.status = ST_NOT_PNG;
                end else begin
                    count = count + 1;
                    if (count >= 8) begin
                        phase     = PH_HDR;
                        count     = '0;
                        hdr_shift = '0;
                        if (last) begin
                            got = 1'b1;
                            r.status = ST_SHORT;
                        end
                    end else if (last) begin
                        got = 1'b1;
                        r.status = ST_NOT_PNG;
                    end
                end
            end
            PH_HDR: begin
                hdr_shift = {hdr_shift[55:0], b};
                count     = count + 1;
                if (last) begin
                    got = 1'b1;
                    r.status = ST_SHORT;
                end else if (count >= 8) begin
                    len        = hdr_shift[63:32];
                    kind       = hdr_shift[31:0];
                    size_chunk = (len == IHDR_LEN) && (kind == IHDR_TYPE);
                    remaining  = len;
                    w_hold     = '0;
                    h_hold     = '0;
                    count      = '0;
                    phase      = (len == 0) ? PH_CRC : PH_DATA;
                end
            end
            PH_DATA: begin
                if (size_chunk) begin
                    idx = IHDR_LEN - remaining;
                    if (idx < 4)
                        w_hold = {w_hold[23:0], b};
                    else if (idx < 8)
                        h_hold = {h_hold[23:0], b};
                end
                if (remaining != 0)
                    remaining = remaining - 1;
                if (remaining == 0) begin
                    if (size_chunk) begin
                        got = 1'b1;
                        if (w_hold == 0 || h_hold == 0) begin
                            r.status = ST_NO_SIZE;
                        end else begin
                            r.status = ST_OK;
                            r.width  = w_hold;
                            r.height = h_hold;
                        end
                    end else begin
                        phase = PH_CRC;
                        count = '0;
                        if (last) begin
                            got = 1'b1;
                            r.status = ST_TRUNC;
                        end
                    end
                end else if (last) begin
                    got = 1'b1;
                    r.status = ST_TRUNC;
                end
            end
            PH_CRC: begin
                count = count + 1;
                if (count >= 4) begin
                    if (last) begin
                        got = 1'b1;
                        r.status = ST_NO_SIZE;
                    end else begin
                        phase     = PH_HDR;
                        count     = '0;
                        hdr_shift = '0;
                    end
                end else if (last) begin
                    got = 1'b1;
                    r.status = ST_TRUNC;
                end
            end
            default: ;
        endcase
        if (got) begin
            phase = PH_DONE;
            expected_dims.push_back(r);
        end
        if (last)
            clear_state();
    endfunction

    function void note_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] seen);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch on result %0d: %s expected 0x%0h, got 0x%0h",
                     results_checked, field, want, seen);
    endfunction

    function void check_result(input t_result seen);
        t_result want;
        if (expected_dims.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result: status %0d width 0x%0h height 0x%0h",
                         seen.status, seen.width, seen.height);
            return;
        end
        want = expected_dims.pop_front();
        results_checked++;
        status_seen[want.status]++;
        if (seen.status != want.status)
            note_mismatch("status", 32'(want.status), 32'(seen.status));
        if (seen.width != want.width)   note_mismatch("width", want.width, seen.width);
        if (seen.height != want.height) note_mismatch("height", want.height, seen.height);
    endfunction

    function int pending();
        return expected_dims.size();
    endfunction
endclass

module tb_png_size_probe;
    timeunit 1ns;
    timeprecision 1ps;

    // receiver stall styles, re-picked at random
    typedef enum logic [1:0] {
        RX_OPEN   = 2'd0,   // always ready
        RX_COIN   = 2'd1,   // ready on a coin flip
        RX_SPARSE = 2'd2,   // ready with a one-in-eight chance
        RX_WAVE   = 2'd3    // ready while bit 2 of rx_tick is set
    } t_rx_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] byte_in
    logic        s_axis_tlast;     // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;     // [31:0] image_width, [63:32] image_height
    logic [2:0]  m_axis_tuser;     // [2:0] status

    png_dims_scoreboard sb;
    t_result            seen_dims;

    logic [7:0]  file_bytes[$];    // buffer under construction
    int unsigned burst_left = 0;
    int unsigned bytes_sent = 0;
    int unsigned files_sent = 0;

    t_rx_mode    rx_mode = RX_OPEN;
    int unsigned rx_hold = 0;
    logic [7:0]  rx_tick = '0;

    png_size_probe u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop. Slowest legit run is well under 200 us even with the sparse
    // receiver and the longest sender gaps on every byte.
    initial begin
        #2_000_000;
        $display("timeout: %0d results still outstanding", sb.pending());
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: stall style changes at random intervals, so back-pressure
    // lands on every parser phase; RX_OPEN gives stretches with no stalls.
    always @(negedge i_clk) begin
        if (rx_hold == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_hold <= $urandom_range(16, 96);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default:   m_axis_tready <= rx_tick[2];
        endcase
        rx_tick <= rx_tick + 8'd1;
    end

    // Result monitor: sampled at the rising edge, before the block updates.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_dims.status = t_status'(m_axis_tuser);
            seen_dims.width  = m_axis_tdata[31:0];
            seen_dims.height = m_axis_tdata[63:32];
            sb.check_result(seen_dims);
        end
    end

    // ---- buffer construction -------------------------------------------

    function automatic void put_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(w[8*i +: 8]);   // big-endian
    endfunction

    function automatic void put_random(input int n);
        repeat (n) file_bytes.push_back(8'($urandom()));
    endfunction

    function automatic void put_signature();
        for (int i = 0; i < 8; i++)
            file_bytes.push_back(PNG_SIGNATURE[8*(7 - i) +: 8]);
    endfunction

    // length, kind, data bytes, CRC (random, never checked by the block)
    function automatic void put_chunk(input logic [31:0] len, input logic [31:0] kind,
                                      input int data_n);
        put_word(len);
        put_word(kind);
        put_random(data_n);
        put_word($urandom());
    endfunction

    // IHDR: width, height, then depth/color/compression/filter/interlace
    function automatic void put_size_chunk(input logic [31:0] w, input logic [31:0] h);
        put_word(IHDR_LEN);
        put_word(IHDR_TYPE);
        put_word(w);
        put_word(h);
        put_random(5);
        put_word($urandom());
    endfunction

    function automatic void cut_file(input int keep);
        while (file_bytes.size() > keep)
            void'(file_bytes.pop_back());
    endfunction

    // dimension values weighted toward the edges
    function automatic logic [31:0] pick_dim();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1;
            3, 4:    return $urandom_range(1, 4096);
            default: return $urandom();
        endcase
    endfunction

    // Well-formed files with random content; some corrupted,
    // some cut short, some pure noise, some with a huge chunk length.
    function automatic void build_random_file();
        int roll;
        int n;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            put_random($urandom_range(1, 12));
            return;
        end
        put_signature();
        if (roll < 15) begin
            // length far beyond the buffer: ends inside the header or data
            put_word({1'b1, 31'($urandom())});
            put_word($urandom());
            put_random($urandom_range(0, 6));
            return;
        end
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0: put_chunk(IHDR_LEN, $urandom(), 13);       // right size, other kind
                1: begin
                    n = $urandom_range(0, 16);                // IHDR kind, any size
                    put_chunk(n, IHDR_TYPE, n);
                end
                default: begin
                    n = $urandom_range(0, 12);
                    put_chunk(n, $urandom(), n);
                end
            endcase
        end
        if ($urandom_range(0, 4) != 0)
            put_size_chunk(pick_dim(), pick_dim());
        put_random($urandom_range(0, 4));   // swallowed after a result
        if (roll < 35) begin
            n = $urandom_range(0, file_bytes.size() - 1);
            file_bytes[n] = file_bytes[n] ^ 8'($urandom_range(1, 255));
        end
        if ($urandom_range(0, 1) == 1)
            cut_file($urandom_range(1, file_bytes.size()));
    endfunction

    // ---- driving ---------------------------------------------------------

    // Entered and left at a falling edge. Sender runs in bursts of 1..24
    // items; a quarter of the bursts follow straight on with no gap.
    task automatic send_item(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_byte(b, last);
        bytes_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // sends the built buffer with tlast on its final byte
    task automatic send_file();
        int n;
        n = file_bytes.size();
        for (int i = 0; i < n; i++)
            send_item(file_bytes[i], i == n - 1);
        file_bytes.delete();
        files_sent++;
    endtask

    task automatic run_directed();
        // lone bytes: both all-zero and all-one fail the signature
        file_bytes.push_back(8'h00);
        send_file();
        file_bytes.push_back(8'hFF);
        send_file();
        // buffer ends inside the signature
        put_signature();
        cut_file(3);
        send_file();
        // mismatch mid-signature, trailing bytes ignored
        put_signature();
        file_bytes[5] = 8'h00;
        put_random(2);
        send_file();
        // signature only: no header follows
        put_signature();
        send_file();
        // ends exactly on the last chunk-header byte
        put_signature();
        put_word(32'h0);
        put_word(32'h7A7A_7A7A);
        send_file();
        // empty chunk, ends right after its CRC: no size found
        put_signature();
        put_chunk(32'h0, 32'h7445_5874, 0);
        send_file();
        // ends inside chunk data, then inside the CRC
        put_signature();
        put_chunk(32'd2, 32'h6741_4D41, 2);
        cut_file(17);
        send_file();
        put_signature();
        put_chunk(32'd2, 32'h6741_4D41, 2);
        cut_file(20);
        send_file();
        // good IHDR with extreme dimensions, bytes after the result ignored
        put_signature();
        put_size_chunk(32'hFFFF_FFFF, 32'h1);
        put_random(3);
        send_file();
        // result byte is also the final byte
        put_signature();
        put_size_chunk(32'h1, 32'hFFFF_FFFF);
        cut_file(29);
        send_file();
        // zero width, then zero height
        put_signature();
        put_size_chunk(32'h0, 32'h10);
        send_file();
        put_signature();
        put_size_chunk(32'h10, 32'h0);
        send_file();
        // 13-byte non-IHDR and a 12-byte IHDR are skipped before the real one
        put_signature();
        put_chunk(IHDR_LEN, 32'h4948_4453, 13);
        put_chunk(32'd12, IHDR_TYPE, 12);
        put_size_chunk(32'h8000_0000, 32'h7FFF_FFFF);
        send_file();
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        while (bytes_sent < 1400) begin
            build_random_file();
            send_file();
        end
        s_axis_tvalid <= 1'b0;

        // drain, then give the registered output path time to show strays
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("sent %0d buffers, %0d bytes; checked %0d results, %0d mismatches",
                 files_sent, bytes_sent, sb.results_checked, sb.fail_count);
        $display("by status: ok %0d, not png %0d, short header %0d, truncated %0d, no size %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], sb.status_seen[4]);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
